// ===== design/pcg32_random_generator_macros.svh =====
// Assertion helpers for the generator.
`ifndef PCG32_RANDOM_GENERATOR_MACROS_SVH
`define PCG32_RANDOM_GENERATOR_MACROS_SVH

// Assert that an antecedent implies a consequent on the next clock.
`define PCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Assert that a condition holds at every clock edge.
`define PCG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== design/pcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pcg_pkg;
  localparam logic [63:0] LcgMult     = 64'd6364136223846793005;
  localparam logic [62:0] StreamReset = 63'd1442695040888963407;
  localparam logic [31:0] SigOrMask   = 32'h8000_0001;

  typedef enum logic [1:0] {
    MODE_RESEED = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_FLOAT  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // XSH-RR output taken from the pre-step state.
  function automatic logic [31:0] pcg_output(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] mixed;
    logic [4:0]  rot;
    x     = ((s >> 18) ^ s) >> 27;
    mixed = x[31:0];
    rot   = s[63:59];
    return (mixed >> rot) | (mixed << ((6'd32 - {1'b0, rot}) & 6'd31));
  endfunction
endpackage
`default_nettype wire

// ===== design/pcg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pcg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] seed_value;
  modport source (output valid, output mode, output seed_value, input ready);
  modport sink (input valid, input mode, input seed_value, output ready);
endinterface

interface pcg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== design/pcg32_random_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// PCG32 XSH-RR generator. A request carries a mode: reseed (no response),
// raw 32-bit draw, or unit-interval float draw (IEEE single bits). Every LCG
// step forms its 64x64 (mod 2^64) product on one shared 32x32 multiplier,
// as four partial products taken in turn in StMul, then an add in StAdd.
// Raw draws take one step, float draws two (one when the first draw is
// zero), reseeds two; a draw then raises its response in StResp. The block
// takes one request at a time; ready is low while a request is in work or a
// response waits. The user must write stream_select (cfg_we_i, cfg_wdata_i)
// only while idle (not enforced); the increment is twice that value plus one.
module pcg32_random_generator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [62:0] cfg_wdata_i,
  pcg_req_if.sink         req,
  pcg_rsp_if.source       rsp
);
  import pcg_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StAdd  = 3'd2;
  localparam logic [2:0] StResp = 3'd3;

  logic [2:0]  st_q, st_d;
  logic [1:0]  pp_q;          // partial product index
  logic [63:0] state_q;
  logic [63:0] acc_q;
  logic [62:0] stream_q;
  logic [1:0]  mode_q;
  logic [63:0] seed_q;
  logic [1:0]  step_q;        // step number within the request
  logic [31:0] first_q;
  logic [31:0] out_q;
  logic        rsp_valid_q;

  // Shared 32x32 multiplier; the partial product is shifted into place.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, prod_sh;
  always_comb begin
    mul_a = pp_q[0] ? state_q[63:32] : state_q[31:0];
    mul_b = pp_q[1] ? LcgMult[63:32] : LcgMult[31:0];
    prod  = {32'd0, mul_a} * {32'd0, mul_b};
    prod_sh = (pp_q == 2'd0) ? prod : (pp_q == 2'd3) ? 64'd0 : (prod << 32);
  end

  // Float assembly from the first draw and the second draw.
  function automatic logic [31:0] to_float(input logic [31:0] first,
                                           input logic [31:0] s2);
    logic [31:0] sig;
    logic [24:0] mant;
    logic        carry;
    logic [5:0]  lz;
    logic [7:0]  biased;
    sig  = s2 | SigOrMask;
    mant = {1'b0, sig[31:8]} + {24'd0, (sig[7:0] > 8'h80)};
    carry = mant[24];
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (first[i]) lz = 6'(31 - i);
    end
    biased = 8'd126 + {7'd0, carry} - {2'd0, lz};
    return {1'b0, biased, carry ? 23'd0 : mant[22:0]};
  endfunction

  logic [63:0] next_state;
  logic [31:0] cur_out;
  assign next_state = acc_q + {stream_q, 1'b1};
  assign cur_out = pcg_output(state_q);

  assign req.ready = (st_q == StIdle) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.value = out_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (req.valid && req.ready &&
                   (req.mode != MODE_NONE)) st_d = StMul;
      StMul:   if (pp_q == 2'd3) st_d = StAdd;
      StAdd: begin
        st_d = StIdle;
        if (mode_q == MODE_RESEED && step_q == 2'd0) st_d = StMul;
        else if (mode_q == MODE_RAW) st_d = StResp;
        else if (mode_q == MODE_FLOAT) begin
          if (step_q == 2'd0 && cur_out != 32'd0) st_d = StMul;
          else st_d = StResp;
        end
      end
      StResp:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      pp_q        <= 2'd0;
      state_q     <= 64'd0;
      stream_q    <= StreamReset;
      rsp_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) stream_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          pp_q   <= 2'd0;
          step_q <= 2'd0;
          acc_q  <= 64'd0;
          if (req.valid && req.ready) begin
            mode_q <= req.mode;
            seed_q <= req.seed_value;
            // Clear the state before the reseed's first step.
            if (req.mode == MODE_RESEED) state_q <= 64'd0;
          end
        end
        StMul: begin
          acc_q <= acc_q + prod_sh;
          pp_q  <= pp_q + 2'd1;
        end
        StAdd: begin
          acc_q  <= 64'd0;
          pp_q   <= 2'd0;
          step_q <= step_q + 2'd1;
          if (mode_q == MODE_RESEED) begin
            state_q <= (step_q == 2'd0) ? next_state + seed_q : next_state;
          end else begin
            state_q <= next_state;
            if (step_q == 2'd0) begin
              first_q <= cur_out;
              out_q   <= (mode_q == MODE_RAW) ? cur_out : 32'd0;
            end else begin
              out_q <= to_float(first_q, cur_out);
            end
          end
        end
        StResp:  rsp_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/pcg_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "pcg32_random_generator_macros.svh"
module pcg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [31:0] rsp_value_i
);
  // No new request while a response waits.
  `PCG_ASSERT_ALWAYS(a_no_ready_rsp, clk_i, rst_ni, !(rsp_valid_i && req_ready_i), "ready with rsp")
  // A response never follows its request in the next cycle.
  `PCG_ASSERT_NEXT(a_busy, clk_i, rst_ni, req_valid_i && req_ready_i, !rsp_valid_i, "rsp too soon")
  // A stalled response holds its value.
  `PCG_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_value_i), "rsp dropped")
endmodule

bind pcg32_random_generator pcg_checker u_pcg_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_value_i(rsp.value)
);
`default_nettype wire

// ===== tb/sv/pcg_rng_checker.sv =====
`timescale 1ns / 1ps
module pcg_rng_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [62:0] cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [1:0]  req_mode_i,
  input  logic [63:0] req_seed_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [31:0] rsp_value_i,
  output int          fail_count_o,
  output int          pending_o
);
  import pcg_pkg::*;

  logic [63:0] gen_state;
  logic [62:0] stream_sel;
  logic [31:0] draw_queue[$];

  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [31:0] m;
    logic [4:0] r;
    m = 32'(((s >> 18) ^ s) >> 27);
    r = s[63:59];
    return (r == 0) ? m : ((m >> r) | (m << (32 - r)));
  endfunction

  // Advance the generator, return the output of the pre-step state.
  function automatic logic [31:0] advance();
    logic [31:0] o;
    o = xsh_rr(gen_state);
    gen_state = gen_state * LcgMult + {stream_sel, 1'b1};
    return o;
  endfunction

  function automatic logic [31:0] unit_float();
    logic [31:0] first, sig;
    logic [24:0] mant;
    logic [7:0] expo;
    int lz;
    first = advance();
    if (first == 0) return 32'd0;
    sig = advance() | SigOrMask;
    mant = {1'b0, sig[31:8]};
    if (sig[7:0] > 8'h80) mant = mant + 1;
    lz = 0;
    while (!first[31 - lz]) lz++;
    expo = 8'(126 - lz);
    if (mant[24]) begin
      mant = 25'h80_0000;
      expo = expo + 1;
    end
    return {1'b0, expo, mant[22:0]};
  endfunction

  assign pending_o = draw_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    logic [31:0] junk;
    if (!rst_ni) begin
      gen_state <= 64'd0;
      stream_sel <= StreamReset;
      fail_count_o <= 0;
      draw_queue.delete();
    end else begin
      if (cfg_we_i) stream_sel = cfg_wdata_i;
      if (req_valid_i && req_ready_i) begin
        case (mode_e'(req_mode_i))
          MODE_RESEED: begin
            gen_state = 64'd0;
            junk = advance();
            gen_state = gen_state + req_seed_i;
            junk = advance();
          end
          MODE_RAW: draw_queue.push_back(advance());
          MODE_FLOAT: draw_queue.push_back(unit_float());
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (draw_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected response %h", rsp_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = draw_queue.pop_front();
          if (want !== rsp_value_i) begin
            if (fail_count_o < 10)
              $display("value: expected %h got %h", want, rsp_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import pcg_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [62:0] cfg_wdata_i = '0;
  int fail_count, pending;
  bit finished = 1'b0;

  pcg_req_if req ();
  pcg_rsp_if rsp ();

  pcg32_random_generator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i), .req(req.sink), .rsp(rsp.source)
  );

  pcg_rng_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(req.valid), .req_ready_i(req.ready), .req_mode_i(req.mode),
    .req_seed_i(req.seed_value), .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready),
    .rsp_value_i(rsp.value), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_RAW;
    req.seed_value = '0;
    rsp.ready = 1'b0;
  end

  // Drop ready for a random, possibly empty, gap before each response.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (!(rsp.valid && rsp.ready)) @(posedge clk_i);
    end
  end

  // Hold one request until the block takes it; idle a random gap before it unless busy is set.
  task automatic send_request(input mode_e m, input logic [63:0] seed, input bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= m;
    req.seed_value <= seed;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  // Write stream_select only once every draw has drained and the block settled.
  task automatic set_stream(input logic [62:0] s);
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [62:0] streams[5];
    int pick;
    bit busy;
    streams = '{63'd0, {63{1'b1}}, StreamReset, 63'h2AAA_AAAA_AAAA_AAAA,
                63'({$urandom(), $urandom()})};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: draws from the zero state, seed extremes, ignored mode, both draws.
    send_request(MODE_RAW, '0, 0);
    send_request(MODE_FLOAT, '0, 0);
    send_request(MODE_NONE, '1, 0);
    send_request(MODE_RAW, '0, 0);
    send_request(MODE_RESEED, '0, 0);
    send_request(MODE_FLOAT, '0, 0);
    send_request(MODE_RESEED, '1, 0);
    send_request(MODE_RAW, '0, 0);
    send_request(MODE_FLOAT, '1, 0);
    send_request(MODE_RESEED, 64'h5555_5555_5555_5555, 0);
    send_request(MODE_FLOAT, '0, 0);
    send_request(MODE_RESEED, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    for (int i = 0; i < 6; i++) send_request(MODE_FLOAT, rand64(), 0);

    // Random phases, one per stream setting, extremes among them.
    for (int p = 0; p < 5; p++) begin
      set_stream(streams[p]);
      for (int i = 0; i < 290; i++) begin
        busy = (i % 60) < 15;
        pick = $urandom_range(0, 19);
        if (pick < 2) send_request(MODE_RESEED, rand64(), busy);
        else if (pick < 3) send_request(MODE_NONE, rand64(), busy);
        else if (pick < 11) send_request(MODE_RAW, rand64(), busy);
        else send_request(MODE_FLOAT, rand64(), busy);
      end
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    finished = 1'b1;
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10ms;
    if (!finished) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end
endmodule
